>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication under reset
`define FLGA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication under reset
`define FLGA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FLGA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FLGA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/flga_pkg.sv
`default_nettype none

package flga_pkg;

    // queue and device geometry
    localparam int QUEUE_DEPTH  = 4;
    localparam int DEVICE_COUNT = 3;
    localparam int FIRST_DEVICE = 3;

    localparam int IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int DEV_W     = 3;
    localparam int HOLD_W    = 4;
    localparam int CID_W     = 2;
    localparam int SLOTS_W   = QUEUE_DEPTH * DEV_W;
    localparam int DEV_IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

    // stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CONTROLLER_ID = 1'b0,
        REG_HOLD_TICKS    = 1'b1
    } cfg_reg_t;

    localparam logic [CID_W-1:0]  CID_RESET        = 2'd1;
    localparam logic [CID_W-1:0]  CID_STANDBY      = 2'd2;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 4'd5;

    typedef enum logic [1:0] {
        MODE_UNSET   = 2'd0,
        MODE_ACTIVE  = 2'd1,
        MODE_STANDBY = 2'd2
    } mode_t;

    // lock queue state
    typedef struct packed {
        logic [HOLD_W-1:0]                 hold;
        logic [IDX_W-1:0]                  head;
        logic [IDX_W-1:0]                  tail;
        logic [QUEUE_DEPTH-1:0][DEV_W-1:0] slot;
    } q_state_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DEV    = 2'd1,
        ST_FINISH = 2'd2
    } fsm_state_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic                 in_ready;
        logic                 dev_step;
        logic [DEV_IDX_W-1:0] dev_idx;
        logic                 finish;
    } seq_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/flga_dev_unit.sv
`default_nettype none

// applies one device message (acquire or release) to the queue state
module flga_dev_unit import flga_pkg::*; (
    input  wire q_state_t          q_in,
    input  wire                    msg_en,
    input  wire                    msg_acquire,
    input  wire [DEV_W-1:0]        msg_dev,
    input  wire [HOLD_W-1:0]       hold_ticks,
    output q_state_t               q_out
);

    logic [IDX_W-1:0] pos;
    logic             done;

    always_comb begin
        q_out = q_in;
        pos   = q_in.head;
        done  = 1'b0;
        if (msg_en) begin
            if (msg_acquire) begin
                // bounded scan from head: insert at tail, stop on duplicate
                for (int n = 0; n < DEVICE_COUNT; n++) begin
                    if (!done) begin
                        if (pos == q_out.tail) begin
                            q_out.slot[pos] = msg_dev;
                            q_out.tail      = pos + IDX_W'(1);
                            done            = 1'b1;
                        end else if (q_out.slot[pos] == msg_dev) begin
                            done = 1'b1;
                        end
                        pos = pos + IDX_W'(1);
                    end
                end
            end else begin
                // release by the head shortens the hold to one tick
                if (q_in.head != q_in.tail && q_in.slot[q_in.head] == msg_dev &&
                    q_in.hold != '0 && q_in.hold < hold_ticks) begin
                    q_out.hold = HOLD_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/flga_ctrl.sv
`default_nettype none

// tick sequencer: accept, one device per cycle, finish
module flga_ctrl import flga_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        in_valid,
    input  wire        out_free,
    output seq_ctrl_t  ctrl
);

    fsm_state_t           state_reg, state_next;
    logic [DEV_IDX_W-1:0] idx_reg, idx_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (in_valid) begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV: begin
                if (idx_reg == DEV_IDX_W'(DEVICE_COUNT - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next = idx_reg + DEV_IDX_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        ctrl          = '0;
        ctrl.dev_idx  = idx_reg;
        unique case (state_reg)
            ST_IDLE:   ctrl.in_ready = 1'b1;
            ST_DEV:    ctrl.dev_step = 1'b1;
            ST_FINISH: ctrl.finish   = out_free;
            default:   ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/failover_lock_grant_arbiter_top.sv
// each tick settles the mode at the accept edge, then applies the device messages,
//   then finishes into the output register that drives m_tvalid
// a new tick is taken only once the sequencer is back in idle, after the shared
//   device-message unit has applied the three device messages one per cycle;
//   finish stalls while the output register still holds an unaccepted result
// reset: synchronous active-low aresetn clears mode, hold, queue and config
//   to controller_id 1 and hold_ticks 5; no clearing pass
`default_nettype none
`include "assert_macros.svh"

module failover_lock_grant_arbiter_top import flga_pkg::*; (
    input  wire                    aclk,
    input  wire                    aresetn,
    // config write port
    input  wire                    cfg_wr_en,
    input  wire [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire [CFG_DATA_W-1:0]   cfg_wdata,
    // tick input
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // peer_valid, peer_hold, peer_head, peer_tail, peer_slots, takeover_valid,
    // dev_valid, dev_is_acquire, zero pad
    input  wire [S_DATA_W-1:0]     s_tdata,
    // result output
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // grant_valid, grant_device, out_mode, out_hold, out_head, out_tail,
    // out_slots, zero pad
    output logic [M_DATA_W-1:0]    m_tdata
);

    // input field slices
    logic                    in_peer_valid;
    logic [HOLD_W-1:0]       in_peer_hold;
    logic [IDX_W-1:0]        in_peer_head;
    logic [IDX_W-1:0]        in_peer_tail;
    logic [SLOTS_W-1:0]      in_peer_slots;
    logic                    in_takeover;
    logic [DEVICE_COUNT-1:0] in_dev_valid;
    logic [DEVICE_COUNT-1:0] in_dev_acq;

    assign in_peer_valid = s_tdata[0];
    assign in_peer_hold  = s_tdata[4:1];
    assign in_peer_head  = s_tdata[6:5];
    assign in_peer_tail  = s_tdata[8:7];
    assign in_peer_slots = s_tdata[20:9];
    assign in_takeover   = s_tdata[21];
    assign in_dev_valid  = s_tdata[24:22];
    assign in_dev_acq    = s_tdata[27:25];

    // configuration registers
    logic [CID_W-1:0]  cid_reg;
    logic [HOLD_W-1:0] hold_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cid_reg        <= CID_RESET;
            hold_ticks_reg <= HOLD_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_CONTROLLER_ID: cid_reg        <= cfg_wdata[CID_W-1:0];
                REG_HOLD_TICKS:    hold_ticks_reg <= cfg_wdata[HOLD_W-1:0];
                default:           cid_reg        <= cid_reg;
            endcase
        end
    end

    // sequencer
    seq_ctrl_t ctrl;
    logic      out_free;
    logic      accept;

    flga_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign s_tready = ctrl.in_ready;
    assign accept   = s_tvalid && s_tready;

    // arbiter state
    mode_t                   mode_reg;
    q_state_t                q_reg;
    logic [DEVICE_COUNT-1:0] dev_valid_reg;
    logic [DEVICE_COUNT-1:0] dev_acq_reg;

    // mode settling on accept
    mode_t    settle_mode;
    q_state_t settle_q;
    q_state_t peer_q;

    always_comb begin
        peer_q.hold = in_peer_hold;
        peer_q.head = in_peer_head;
        peer_q.tail = in_peer_tail;
        peer_q.slot = in_peer_slots;
        settle_mode = mode_reg;
        settle_q    = q_reg;
        unique case (mode_reg)
            MODE_UNSET: begin
                if (in_peer_valid) begin
                    settle_q    = peer_q;
                    settle_mode = MODE_STANDBY;
                end else begin
                    settle_mode = (cid_reg == CID_STANDBY) ? MODE_STANDBY : MODE_ACTIVE;
                end
            end
            MODE_ACTIVE: begin
                if (in_peer_valid && in_takeover) begin
                    settle_mode = MODE_STANDBY;
                end
            end
            default: begin
                if (in_peer_valid) begin
                    settle_q = peer_q;
                    if (in_takeover) begin
                        settle_mode = MODE_ACTIVE;
                    end
                end else begin
                    settle_mode = MODE_ACTIVE;
                    // grant may not have gone out
                    if (q_reg.hold == hold_ticks_reg) begin
                        settle_q.hold = '0;
                    end
                end
            end
        endcase
    end

    // shared device-message unit
    q_state_t          unit_q;
    logic [DEV_W-1:0]  unit_dev;

    assign unit_dev = DEV_W'(FIRST_DEVICE) + DEV_W'(ctrl.dev_idx);

    flga_dev_unit u_dev_unit (
        .q_in        (q_reg),
        .msg_en      (dev_valid_reg[ctrl.dev_idx]),
        .msg_acquire (dev_acq_reg[ctrl.dev_idx]),
        .msg_dev     (unit_dev),
        .hold_ticks  (hold_ticks_reg),
        .q_out       (unit_q)
    );

    // countdown and grant
    q_state_t         fin_q;
    logic [DEV_W-1:0] head_dev;
    logic             fin_grant;
    logic [DEV_W-1:0] fin_dev;

    always_comb begin
        fin_q     = q_reg;
        fin_grant = 1'b0;
        fin_dev   = '0;
        if (fin_q.hold == HOLD_W'(1)) begin
            fin_q.hold = '0;
            fin_q.head = fin_q.head + IDX_W'(1);
        end else if (fin_q.hold > HOLD_W'(1)) begin
            fin_q.hold = fin_q.hold - HOLD_W'(1);
        end
        head_dev = fin_q.slot[fin_q.head];
        if (fin_q.hold == '0 && fin_q.head != fin_q.tail) begin
            fin_q.hold = hold_ticks_reg;
            if (mode_reg == MODE_ACTIVE && head_dev >= DEV_W'(FIRST_DEVICE) &&
                {1'b0, head_dev} < (DEV_W+1)'(FIRST_DEVICE + DEVICE_COUNT)) begin
                fin_grant = 1'b1;
                fin_dev   = head_dev;
            end
        end
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_UNSET;
            q_reg    <= '0;
        end else if (accept) begin
            mode_reg <= settle_mode;
            q_reg    <= settle_q;
        end else if (ctrl.dev_step) begin
            q_reg    <= unit_q;
        end else if (ctrl.finish) begin
            q_reg    <= fin_q;
        end
    end

    // captured device messages
    always_ff @(posedge aclk) begin
        if (accept) begin
            dev_valid_reg <= in_dev_valid;
            dev_acq_reg   <= in_dev_acq;
        end
    end

    // output register
    logic                m_valid_reg;
    logic                grant_valid_reg;
    logic [DEV_W-1:0]    grant_dev_reg;
    mode_t               out_mode_reg;
    q_state_t            out_q_reg;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish) begin
            grant_valid_reg <= fin_grant;
            grant_dev_reg   <= fin_dev;
            out_mode_reg    <= mode_reg;
            out_q_reg       <= fin_q;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_q_reg.slot, out_q_reg.tail, out_q_reg.head,
                       out_q_reg.hold, out_mode_reg, grant_dev_reg, grant_valid_reg};

    // checks
    `FLGA_ASSERT_IMP(a_grant_when_active, aclk, aresetn,
        m_valid_reg && grant_valid_reg, out_mode_reg == MODE_ACTIVE)
    `FLGA_ASSERT_IMP(a_grant_restarts_hold, aclk, aresetn,
        m_valid_reg && grant_valid_reg, out_q_reg.hold == hold_ticks_reg)
    `FLGA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn,
        s_tvalid && s_tready, !s_tready && !ctrl.finish)

endmodule

`default_nettype wire

>>> dv/tb_failover_lock_grant_arbiter_top.sv
`default_nettype none

module tb_failover_lock_grant_arbiter_top;
    import flga_pkg::*;

    // one tick as it travels on s_tdata, lowest field last
    typedef struct packed {
        logic [DEVICE_COUNT-1:0] dev_is_acquire;
        logic [DEVICE_COUNT-1:0] dev_valid;
        logic                    takeover_valid;
        logic [SLOTS_W-1:0]      peer_slots;
        logic [IDX_W-1:0]        peer_tail;
        logic [IDX_W-1:0]        peer_head;
        logic [HOLD_W-1:0]       peer_hold;
        logic                    peer_valid;
    } tick_t;

    // one heartbeat as it travels on m_tdata, lowest field last
    typedef struct packed {
        logic [SLOTS_W-1:0] out_slots;
        logic [IDX_W-1:0]   out_tail;
        logic [IDX_W-1:0]   out_head;
        logic [HOLD_W-1:0]  out_hold;
        mode_t              out_mode;
        logic [DEV_W-1:0]   grant_device;
        logic               grant_valid;
    } beat_t;

    // lock queue and mode tracker, predicts the heartbeat of every tick
    class grant_beat_board;
        mode_t             mode;
        logic [CID_W-1:0]  ctrl_id;
        logic [HOLD_W-1:0] hold_ticks;
        logic [HOLD_W-1:0] hold;
        logic [IDX_W-1:0]  head;
        logic [IDX_W-1:0]  tail;
        logic [DEV_W-1:0]  slot [QUEUE_DEPTH];
        beat_t             expected_beats [$];
        int                errors;

        function new();
            mode       = MODE_UNSET;
            ctrl_id    = CID_RESET;
            hold_ticks = HOLD_TICKS_RESET;
            hold       = '0;
            head       = '0;
            tail       = '0;
            foreach (slot[k]) slot[k] = '0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_CONTROLLER_ID: ctrl_id = val[CID_W-1:0];
                REG_HOLD_TICKS:    hold_ticks = val[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // take over the partner's hold counter and queue
        function void adopt_peer(tick_t t);
            hold = t.peer_hold;
            head = t.peer_head;
            tail = t.peer_tail;
            for (int k = 0; k < QUEUE_DEPTH; k++) slot[k] = t.peer_slots[DEV_W*k +: DEV_W];
        endfunction

        // search from the head for the tail or a duplicate, bounded scan
        function void join_queue(logic [DEV_W-1:0] dev);
            logic [IDX_W-1:0] pos;
            pos = head;
            for (int n = 0; n < DEVICE_COUNT; n++) begin
                if (pos == tail) begin
                    slot[pos] = dev;
                    tail = pos + 1'b1;
                    return;
                end
                if (slot[pos] == dev) return;
                pos = pos + 1'b1;
            end
        endfunction

        function void take_tick(tick_t t);
            beat_t            e;
            logic [DEV_W-1:0] dev;
            logic [DEV_W-1:0] head_dev;

            // mode settling
            case (mode)
                MODE_UNSET: begin
                    if (t.peer_valid) begin
                        adopt_peer(t);
                        mode = MODE_STANDBY;
                    end else begin
                        mode = (ctrl_id == CID_STANDBY) ? MODE_STANDBY : MODE_ACTIVE;
                    end
                end
                MODE_ACTIVE: begin
                    if (t.peer_valid && t.takeover_valid) mode = MODE_STANDBY;
                end
                default: begin
                    if (t.peer_valid) begin
                        adopt_peer(t);
                        if (t.takeover_valid) mode = MODE_ACTIVE;
                    end else begin
                        mode = MODE_ACTIVE;
                        if (hold == hold_ticks) hold = '0;
                    end
                end
            endcase

            // device messages in device order
            for (int i = 0; i < DEVICE_COUNT; i++) begin
                if (t.dev_valid[i]) begin
                    dev = DEV_W'(FIRST_DEVICE + i);
                    if (t.dev_is_acquire[i]) begin
                        join_queue(dev);
                    end else if (head != tail && slot[head] == dev &&
                                 hold > 0 && hold < hold_ticks) begin
                        hold = HOLD_W'(1);
                    end
                end
            end

            // hold countdown, head advances on expiry
            if (hold == 1) begin
                hold = '0;
                head = head + 1'b1;
            end else if (hold > 1) begin
                hold = hold - 1'b1;
            end

            // restart the hold and grant the head
            e = '0;
            head_dev = slot[head];
            if (hold == 0 && head != tail) begin
                hold = hold_ticks;
                if (mode == MODE_ACTIVE && head_dev >= FIRST_DEVICE &&
                    head_dev < FIRST_DEVICE + DEVICE_COUNT) begin
                    e.grant_valid  = 1'b1;
                    e.grant_device = head_dev;
                end
            end

            e.out_mode = mode;
            e.out_hold = hold;
            e.out_head = head;
            e.out_tail = tail;
            for (int k = 0; k < QUEUE_DEPTH; k++) e.out_slots[DEV_W*k +: DEV_W] = slot[k];
            expected_beats.push_back(e);
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [M_DATA_W-1:0] d);
            beat_t e;
            beat_t got;
            if (expected_beats.size() == 0) begin
                $error("heartbeat transaction with none expected: %h", d);
                errors++;
                return;
            end
            e   = expected_beats.pop_front();
            got = d[$bits(beat_t)-1:0];
            cmp_field("grant_valid", e.grant_valid, got.grant_valid);
            cmp_field("grant_device", e.grant_device, got.grant_device);
            cmp_field("out_mode", e.out_mode, got.out_mode);
            cmp_field("out_hold", e.out_hold, got.out_hold);
            cmp_field("out_head", e.out_head, got.out_head);
            cmp_field("out_tail", e.out_tail, got.out_tail);
            cmp_field("out_slots", e.out_slots, got.out_slots);
            cmp_field("pad", 0, d[M_DATA_W-1:$bits(beat_t)]);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    wire                   s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    wire                   m_tvalid;
    logic                  m_tready;
    wire  [M_DATA_W-1:0]   m_tdata;

    grant_beat_board board;
    bit              src_quiet;
    bit              sink_quiet;

    failover_lock_grant_arbiter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic tick_t tick_of(logic pv, logic [HOLD_W-1:0] ph, logic [IDX_W-1:0] phd,
                                      logic [IDX_W-1:0] ptl, logic [SLOTS_W-1:0] ps,
                                      logic tk, logic [2:0] dv, logic [2:0] da);
        tick_t t;
        t.peer_valid     = pv;
        t.peer_hold      = ph;
        t.peer_head      = phd;
        t.peer_tail      = ptl;
        t.peer_slots     = ps;
        t.takeover_valid = tk;
        t.dev_valid      = dv;
        t.dev_is_acquire = da;
        return t;
    endfunction

    // mostly plausible ticks with real device ids, some pure noise
    function automatic tick_t rand_tick();
        tick_t t;
        if ($urandom_range(0, 9) < 7) begin
            t.peer_valid     = ($urandom_range(0, 4) == 0);
            t.peer_hold      = HOLD_W'($urandom_range(0, 15));
            t.peer_head      = IDX_W'($urandom_range(0, 3));
            t.peer_tail      = IDX_W'($urandom_range(0, 3));
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                t.peer_slots[DEV_W*k +: DEV_W] =
                    ($urandom_range(0, 7) == 0) ? DEV_W'($urandom) : DEV_W'($urandom_range(3, 5));
            end
            t.takeover_valid = ($urandom_range(0, 2) == 0);
            t.dev_valid      = DEVICE_COUNT'($urandom_range(0, 7));
            for (int i = 0; i < DEVICE_COUNT; i++) t.dev_is_acquire[i] = ($urandom_range(0, 3) != 0);
        end else begin
            t = $bits(tick_t)'($urandom);
        end
        return t;
    endfunction

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        board.write_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one tick transaction with a random gap in front
    task automatic send_tick(tick_t t);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(t);
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.take_tick(t);
    endtask

    // stop sending until every heartbeat has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.expected_beats.size() != 0);
    endtask

    // result side with random stalls
    initial begin
        int gap;
        int seen;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (seen % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
            gap = sink_quiet ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            board.check_beat(m_tdata);
            seen++;
        end
    end

    // reset, then directed ticks, then random phases over several settings
    initial begin
        logic [CID_W-1:0]  cid_plan [7];
        logic [HOLD_W-1:0] hold_plan [7];
        board     = new();
        cid_plan  = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
        hold_plan = '{4'd2, 4'd15, 4'd1, 4'd0, 4'd5, 4'd3, 4'($urandom_range(0, 15))};
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_CONTROLLER_ID;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 7; p++) begin
            write_register(REG_CONTROLLER_ID, CFG_DATA_W'(cid_plan[p]));
            write_register(REG_HOLD_TICKS, CFG_DATA_W'(hold_plan[p]));
            if (p == 0) begin
                // start as standby with no heartbeat, then fail over to active
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b000, 3'b000));
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b111, 3'b111));
                // release by a device that is not the head
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b010, 3'b000));
                // release by the head
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b001, 3'b000));
                // duplicate acquires, queue wraps around
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b111, 3'b111));
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b111, 3'b111));
                // heartbeat without takeover keeps active
                send_tick(tick_of(1, 15, 3, 3, 12'hfff, 0, 3'b000, 3'b000));
                send_tick(tick_of(1, 2, 0, 1, 12'o0003, 0, 3'b100, 3'b100));
                // takeover drops to standby
                send_tick(tick_of(1, 0, 0, 0, 0, 1, 3'b000, 3'b000));
                // standby copies a queue with odd slot values
                send_tick(tick_of(1, 0, 0, 2, 12'o7210, 0, 3'b000, 3'b000));
                // back to active with a head slot that is no device
                send_tick(tick_of(1, 0, 1, 3, 12'o7210, 1, 3'b000, 3'b000));
                // full queue of foreign values drops every acquire
                send_tick(tick_of(1, 1, 0, 3, 12'o0210, 1, 3'b111, 3'b111));
                send_tick(tick_of(1, 0, 0, 3, 12'o0210, 1, 3'b111, 3'b111));
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b111, 3'b111));
                // all ones and all zeros
                send_tick(tick_of(1, 15, 3, 3, 12'hfff, 1, 3'b111, 3'b111));
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b000, 3'b000));
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b111, 3'b000));
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b111, 3'b101));
                send_tick(tick_of(1, 2, 3, 0, 12'o5435, 1, 3'b011, 3'b001));
                send_tick(tick_of(0, 0, 0, 0, 0, 0, 3'b110, 3'b010));
            end
            for (int n = 0; n < 150; n++) begin
                if (n % 50 == 0) src_quiet = ($urandom_range(0, 3) == 0);
                send_tick(rand_tick());
            end
            drain();
        end

        repeat (12) @(posedge aclk);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> failover_lock_grant_arbiter_top.f
+incdir+hw/rtl
hw/rtl/flga_pkg.sv
hw/rtl/flga_dev_unit.sv
hw/rtl/flga_ctrl.sv
hw/rtl/failover_lock_grant_arbiter_top.sv
dv/tb_failover_lock_grant_arbiter_top.sv
